[sv/fpcvt_pkg.sv]
package fpcvt_pkg;

    localparam int unsigned OPERAND_W = 64;
    localparam int unsigned S_EXP_W   = 8;
    localparam int unsigned S_FRAC_W  = 23;
    localparam int unsigned D_EXP_W   = 11;
    localparam int unsigned D_FRAC_W  = 52;

    localparam logic [D_EXP_W-1:0] D_EXP_MAX = 11'h7FF;
    localparam logic [S_EXP_W-1:0] S_EXP_MAX = 8'hFF;
    localparam logic [D_EXP_W-1:0] BIAS_DIFF = 11'd896;

    localparam logic MODE_WIDEN  = 1'b0;
    localparam logic MODE_NARROW = 1'b1;

    // Decoded operand classes handed from decode to the compute stage
    typedef struct packed {
        logic       mode;
        logic       sign;
        logic       is_special;
        logic       is_zero;
        logic [4:0] lz;
    } cls_t;

    // Count leading zeros of a 23-bit single fraction
    function automatic logic [4:0] clz23(input logic [S_FRAC_W-1:0] f);
        logic [4:0] n;
        logic       found;
        n = 5'd23;
        found = 1'b0;
        for (int i = S_FRAC_W - 1; i >= 0; i--)
        begin
            if (!found && f[i])
            begin
                n = 5'(S_FRAC_W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[sv/fpcvt_decode.sv]
module fpcvt_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          mode,
    input  logic [fpcvt_pkg::OPERAND_W-1:0] operand_bits,
    output logic                          out_valid,
    output fpcvt_pkg::cls_t               cls,
    output logic [fpcvt_pkg::OPERAND_W-1:0] op
);
    import fpcvt_pkg::*;

    logic                 valid_reg;
    cls_t                 cls_reg;
    cls_t                 cls_next;
    logic [OPERAND_W-1:0] op_reg;

    // Classify operand and count leading zeros of a single fraction
    always_comb
    begin
        cls_next.mode = mode;
        if (mode == MODE_WIDEN)
        begin
            cls_next.sign       = operand_bits[31];
            cls_next.is_special = operand_bits[30:23] == S_EXP_MAX;
            cls_next.is_zero    = operand_bits[30:23] == '0;
        end
        else
        begin
            cls_next.sign       = operand_bits[63];
            cls_next.is_special = operand_bits[62:52] == D_EXP_MAX;
            cls_next.is_zero    = operand_bits[62:52] == '0;
        end
        cls_next.lz = clz23(operand_bits[S_FRAC_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
        op_reg  <= operand_bits;
    end

    assign out_valid = valid_reg;
    assign cls       = cls_reg;
    assign op        = op_reg;
endmodule

[sv/fpcvt_compute.sv]
module fpcvt_compute (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  fpcvt_pkg::cls_t               cls,
    input  logic [fpcvt_pkg::OPERAND_W-1:0] op,
    output logic                          out_valid,
    output logic [fpcvt_pkg::OPERAND_W-1:0] pre,
    output logic                          inc,
    output logic                          ovf_chk,
    output logic                          mode_o
);
    import fpcvt_pkg::*;

    logic                 valid_reg;
    logic [OPERAND_W-1:0] pre_reg;
    logic [OPERAND_W-1:0] pre_next;
    logic                 inc_reg;
    logic                 inc_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 mode_reg;

    logic [S_FRAC_W-1:0]  sf;
    logic [S_FRAC_W-1:0]  sf_norm;
    logic [D_EXP_W-1:0]   de;
    logic [D_FRAC_W-1:0]  df;
    logic [S_FRAC_W-1:0]  top;
    logic [12:0]          se;
    logic [4:0]           sh;
    logic [S_FRAC_W:0]    mant;
    logic [S_FRAC_W:0]    mant_sh;
    logic                 rnd;
    logic                 sticky;

    // Build result before rounding increment
    always_comb
    begin
        sf       = op[S_FRAC_W-1:0];
        sf_norm  = (sf << cls.lz) << 1;
        de       = op[62:52];
        df       = op[D_FRAC_W-1:0];
        top      = df[51:29];
        se       = {2'b00, de} - {2'b00, BIAS_DIFF};
        sh       = 5'd0;
        mant     = {1'b1, top};
        mant_sh  = '0;
        rnd      = df[28];
        sticky   = df[27:0] != '0;
        inc_next = 1'b0;
        ovf_next = 1'b0;
        pre_next = '0;
        if (cls.mode == MODE_WIDEN)
        begin
            if (cls.is_special)
                pre_next = {cls.sign, D_EXP_MAX, sf, 29'd0};
            else if (cls.is_zero)
            begin
                if (sf == '0)
                    pre_next = {cls.sign, 63'd0};
                else
                    pre_next = {cls.sign, BIAS_DIFF - D_EXP_W'(cls.lz), sf_norm, 29'd0};
            end
            else
                pre_next = {cls.sign, D_EXP_W'(op[30:23]) + BIAS_DIFF, sf, 29'd0};
        end
        else
        begin
            if (cls.is_special)
                pre_next = {32'd0, cls.sign, S_EXP_MAX,
                    (df != '0 && top == '0) ? 23'd1 : top};
            else if (cls.is_zero)
                pre_next = {32'd0, cls.sign, 31'd0};
            else if (!se[12] && se >= 13'd255)
                pre_next = {32'd0, cls.sign, S_EXP_MAX, 23'd0};
            else if (se[12] || se == '0)
            begin
                // Denormal result: truncate
                if (se[12] && se < 13'h1FE9)
                    pre_next = {32'd0, cls.sign, 31'd0};
                else
                begin
                    sh      = 5'(13'd1 - se);
                    mant_sh = mant >> sh;
                    pre_next = {32'd0, cls.sign, 7'd0, mant_sh};
                end
            end
            else
            begin
                pre_next = {32'd0, cls.sign, se[7:0], top};
                inc_next = rnd && (sticky || top[0]);
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        pre_reg  <= pre_next;
        inc_reg  <= inc_next;
        ovf_reg  <= ovf_next;
        mode_reg <= cls.mode;
    end

    assign out_valid = valid_reg;
    assign pre       = pre_reg;
    assign inc       = inc_reg;
    assign ovf_chk   = ovf_reg;
    assign mode_o    = mode_reg;
endmodule

[sv/fpcvt_round.sv]
module fpcvt_round (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fpcvt_pkg::OPERAND_W-1:0] pre,
    input  logic                          inc,
    input  logic                          ovf_chk,
    input  logic                          mode,
    output logic                          out_valid,
    output logic [fpcvt_pkg::OPERAND_W-1:0] result
);
    import fpcvt_pkg::*;

    logic                 valid_reg;
    logic [OPERAND_W-1:0] result_reg;
    logic [OPERAND_W-1:0] result_next;
    logic [30:0]          sum;

    // Add rounding increment; a carry into all-ones exponent gives infinity
    always_comb
    begin
        sum = pre[30:0] + 31'(inc);
        result_next = pre;
        if (mode == MODE_NARROW && ovf_chk)
        begin
            if (sum[30:23] == S_EXP_MAX)
                result_next = {32'd0, pre[31], S_EXP_MAX, 23'd0};
            else
                result_next = {32'd0, pre[31], sum};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Hold result for output
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
endmodule

[sv/fp32_fp64_format_converter.sv]
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+--------------------------
// request  | start, mode, operand_bits     | taken when start && !busy
// result   | done, result_bits             | one-cycle strobe on done
//
// Three register stages: decode with leading-zero count, convert, round.
// A request passes the decode, convert and round registers in that order; done is the round stage's registered valid.
// One request enters every cycle; busy is held low.
// Reset clears only the stage valid bits.
module fp32_fp64_format_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [fpcvt_pkg::OPERAND_W-1:0] operand_bits,
    output logic                          done,
    output logic [fpcvt_pkg::OPERAND_W-1:0] result_bits
);
    import fpcvt_pkg::*;

    logic                 v1;
    cls_t                 cls1;
    logic [OPERAND_W-1:0] op1;
    logic                 v2;
    logic [OPERAND_W-1:0] pre2;
    logic                 inc2;
    logic                 ovf2;
    logic                 mode2;

    assign busy = 1'b0;

    fpcvt_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .mode         (mode),
        .operand_bits (operand_bits),
        .out_valid    (v1),
        .cls          (cls1),
        .op           (op1)
    );

    fpcvt_compute u_compute (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .cls       (cls1),
        .op        (op1),
        .out_valid (v2),
        .pre       (pre2),
        .inc       (inc2),
        .ovf_chk   (ovf2),
        .mode_o    (mode2)
    );

    fpcvt_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .pre       (pre2),
        .inc       (inc2),
        .ovf_chk   (ovf2),
        .mode      (mode2),
        .out_valid (done),
        .result    (result_bits)
    );
endmodule
